@@ design/gbsp_pkg.sv @@
// Shared types and constants of the grid breadth-first shortest path block.
`timescale 1ns / 1ps

package gbsp_pkg;

	// Fixed field widths of the interface
	localparam int CFG_W   = 6;
	localparam int COORD_W = 5;
	localparam int DIST_W  = 10;
	// Width used for the side, bound and target comparisons
	localparam int CMP_W   = 7;

	localparam logic [CFG_W-1:0]  GRID_SIDE_RESET = 6'd32;
	localparam logic [DIST_W-1:0] DIST_MAX        = 10'd1023;

	// Request codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Neighbour visiting order
	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_LEFT  = 2'd1,
		DIR_RIGHT = 2'd2,
		DIR_DOWN  = 2'd3
	} dir_t;

	// Result selection
	typedef enum logic [1:0] {
		RES_SAME  = 2'd0,
		RES_NONE  = 2'd1,
		RES_FOUND = 2'd2
	} res_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CLEAR,
		ST_SEED,
		ST_POP,
		ST_LOAD,
		ST_NB,
		ST_CHK,
		ST_FINISH
	} ctrl_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic     ld_query;
		logic     wall_wr;
		logic     check;
		logic     clr_step;
		logic     seed;
		logic     pop;
		logic     load;
		logic     nb_step;
		logic     rd_nb;
		logic     visit;
		logic     enq;
		logic     res_set;
		res_sel_t res_sel;
		logic     out_load;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic same;
		logic oob;
		logic clr_last;
		logic q_empty;
		logic nb_ok;
		logic k_last;
		logic cand;
		logic hit;
	} dp_status_t;

endpackage

@@ design/gbsp_dp.sv @@
// Datapath: map memories, frontier queue, neighbour generation and result registers.
`timescale 1ns / 1ps

module gbsp_dp import gbsp_pkg::*; #(
	parameter int GRID_SIDE = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_status_t         status,
	input  logic               cfg_wr_en,
	input  logic [CFG_W-1:0]   cfg_wr_data,
	input  logic [COORD_W-1:0] row,
	input  logic [COORD_W-1:0] col,
	input  logic               wall,
	input  logic [COORD_W-1:0] dest_row,
	input  logic [COORD_W-1:0] dest_col,
	output logic [DIST_W-1:0]  distance,
	output logic               reachable
);

	localparam int CW    = $clog2(GRID_SIDE);
	localparam int AW    = 2 * CW;
	localparam int DEPTH = 1 << AW;
	localparam int PW    = AW + 1;
	localparam int DW    = AW;
	localparam int QW    = DW + AW;
	localparam int XW    = (DW > DIST_W) ? DW : DIST_W;

	logic [CFG_W-1:0]   grid_side_q;
	logic [COORD_W-1:0] qs_row_q, qs_col_q, qd_row_q, qd_col_q;
	logic [AW-1:0]      clr_q;
	logic [PW-1:0]      head_q, tail_q;
	logic [CW-1:0]      cur_r_q, cur_c_q;
	logic [DW-1:0]      cur_d_q;
	dir_t               k_q;
	logic               wall_rd_q, vis_rd_q;
	logic [QW-1:0]      q_rd_q;
	logic [DIST_W-1:0]  res_dist_q, distance_q;
	logic               res_ok_q, reachable_q;

	logic wall_mem [DEPTH];
	logic vis_mem  [DEPTH];
	logic [QW-1:0] q_mem [DEPTH];

	logic [CMP_W-1:0] side;
	logic [CW-1:0]    nb_r, nb_c;
	logic             nb_in;
	logic [AW-1:0]    nb_addr, start_addr;
	logic [DW-1:0]    next_d;
	logic [XW-1:0]    next_dx;
	logic [DIST_W-1:0] found_dist;
	logic             vis_we, vis_wdata;
	logic [AW-1:0]    vis_waddr;
	logic             q_we;
	logic [QW-1:0]    q_wdata;
	logic [AW-1:0]    q_waddr;
	logic [AW-1:0]    wr_addr;
	logic             wr_in;

	// Active side, saturated to the built map
	always_comb begin
		if (CMP_W'(grid_side_q) > CMP_W'(GRID_SIDE)) begin
			side = CMP_W'(GRID_SIDE);
		end else begin
			side = CMP_W'(grid_side_q);
		end
	end

	// Neighbour of the current cell in the current direction
	always_comb begin
		nb_r  = cur_r_q;
		nb_c  = cur_c_q;
		nb_in = 1'b0;
		case (k_q)
			DIR_UP: begin
				nb_r  = cur_r_q - CW'(1);
				nb_in = (cur_r_q != '0);
			end
			DIR_LEFT: begin
				nb_c  = cur_c_q - CW'(1);
				nb_in = (cur_c_q != '0);
			end
			DIR_RIGHT: begin
				nb_c  = cur_c_q + CW'(1);
				nb_in = (CMP_W'(cur_c_q) + CMP_W'(1)) < side;
			end
			DIR_DOWN: begin
				nb_r  = cur_r_q + CW'(1);
				nb_in = (CMP_W'(cur_r_q) + CMP_W'(1)) < side;
			end
			default: begin
				nb_in = 1'b0;
			end
		endcase
	end

	assign nb_addr    = {nb_r, nb_c};
	assign start_addr = {CW'(qs_row_q), CW'(qs_col_q)};
	assign next_d     = cur_d_q + DW'(1);
	assign next_dx    = XW'(next_d);
	assign found_dist = (next_dx > XW'(DIST_MAX)) ? DIST_MAX : next_dx[DIST_W-1:0];
	assign wr_addr    = {CW'(row), CW'(col)};
	assign wr_in      = (CMP_W'(row) < CMP_W'(GRID_SIDE)) && (CMP_W'(col) < CMP_W'(GRID_SIDE));

	// Status to the controller
	always_comb begin
		status.same     = (qs_row_q == qd_row_q) && (qs_col_q == qd_col_q);
		status.oob      = (CMP_W'(qs_row_q) >= side) || (CMP_W'(qs_col_q) >= side) ||
		                  (CMP_W'(qd_row_q) >= side) || (CMP_W'(qd_col_q) >= side);
		status.clr_last = (clr_q == {AW{1'b1}});
		status.q_empty  = (head_q == tail_q);
		status.nb_ok    = nb_in;
		status.k_last   = (k_q == DIR_DOWN);
		status.cand     = !wall_rd_q && !vis_rd_q;
		status.hit      = (CMP_W'(nb_r) == CMP_W'(qd_row_q)) &&
		                  (CMP_W'(nb_c) == CMP_W'(qd_col_q));
	end

	// Visited map write port selection
	always_comb begin
		vis_we    = 1'b0;
		vis_waddr = nb_addr;
		vis_wdata = 1'b1;
		if (cmd.clr_step) begin
			vis_we    = 1'b1;
			vis_waddr = clr_q;
			vis_wdata = 1'b0;
		end else if (cmd.seed) begin
			vis_we    = 1'b1;
			vis_waddr = start_addr;
		end else if (cmd.visit) begin
			vis_we    = 1'b1;
		end
	end

	// Frontier queue write port selection; the seed always lands in the first slot
	always_comb begin
		q_we    = cmd.seed | cmd.enq;
		q_wdata = cmd.seed ? {DW'(0), start_addr} : {next_d, nb_addr};
		q_waddr = cmd.seed ? '0 : tail_q[AW-1:0];
	end

	// Wall map
	always_ff @(posedge clk) begin
		if (cmd.wall_wr && wr_in) begin
			wall_mem[wr_addr] <= wall;
		end
		if (cmd.rd_nb) begin
			wall_rd_q <= wall_mem[nb_addr];
		end
	end

	// Visited map
	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_waddr] <= vis_wdata;
		end
		if (cmd.rd_nb) begin
			vis_rd_q <= vis_mem[nb_addr];
		end
	end

	// Frontier queue
	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[q_waddr] <= q_wdata;
		end
		if (cmd.pop) begin
			q_rd_q <= q_mem[head_q[AW-1:0]];
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= GRID_SIDE_RESET;
		end else if (cfg_wr_en) begin
			grid_side_q <= cfg_wr_data;
		end
	end

	// Queue pointers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			head_q <= '0;
			tail_q <= '0;
			k_q    <= DIR_UP;
		end else begin
			if (cmd.check) begin
				clr_q <= '0;
			end else if (cmd.clr_step) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.seed) begin
				head_q <= '0;
				tail_q <= PW'(1);
			end else begin
				if (cmd.pop) begin
					head_q <= head_q + PW'(1);
				end
				if (cmd.enq) begin
					tail_q <= tail_q + PW'(1);
				end
			end
			if (cmd.load) begin
				k_q <= DIR_UP;
			end else if (cmd.nb_step) begin
				k_q <= dir_t'(k_q + 2'd1);
			end
		end
	end

	// Query fields, current cell and results
	always_ff @(posedge clk) begin
		if (cmd.ld_query) begin
			qs_row_q <= row;
			qs_col_q <= col;
			qd_row_q <= dest_row;
			qd_col_q <= dest_col;
		end
		if (cmd.load) begin
			{cur_d_q, cur_r_q, cur_c_q} <= q_rd_q;
		end
		if (cmd.res_set) begin
			case (cmd.res_sel)
				RES_SAME: begin
					res_dist_q <= '0;
					res_ok_q   <= 1'b1;
				end
				RES_FOUND: begin
					res_dist_q <= found_dist;
					res_ok_q   <= 1'b1;
				end
				default: begin
					res_dist_q <= '0;
					res_ok_q   <= 1'b0;
				end
			endcase
		end
		if (cmd.out_load) begin
			distance_q  <= res_dist_q;
			reachable_q <= res_ok_q;
		end
	end

	assign distance  = distance_q;
	assign reachable = reachable_q;

endmodule

@@ design/gbsp_ctrl.sv @@
// Controller: sequences map writes, the clearing pass and the search.
`timescale 1ns / 1ps

module gbsp_ctrl import gbsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       req_type,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || !out_stall;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && req_type == REQ_QUERY) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.same || status.oob) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				if (status.clr_last) begin
					state_d = ST_SEED;
				end
			end
			ST_SEED: begin
				state_d = ST_POP;
			end
			ST_POP: begin
				if (status.q_empty) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_NB;
			end
			ST_NB: begin
				if (status.nb_ok) begin
					state_d = ST_CHK;
				end else if (status.k_last) begin
					state_d = ST_POP;
				end
			end
			ST_CHK: begin
				if (status.cand && status.hit) begin
					state_d = ST_FINISH;
				end else if (status.k_last) begin
					state_d = ST_POP;
				end else begin
					state_d = ST_NB;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall     = 1'b0;
				cmd.ld_query = in_valid && (req_type == REQ_QUERY);
				cmd.wall_wr  = in_valid && (req_type == REQ_WRITE);
			end
			ST_CHECK: begin
				cmd.check   = 1'b1;
				cmd.res_set = status.same || status.oob;
				cmd.res_sel = status.same ? RES_SAME : RES_NONE;
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			ST_SEED: begin
				cmd.seed = 1'b1;
			end
			ST_POP: begin
				cmd.pop     = !status.q_empty;
				cmd.res_set = status.q_empty;
				cmd.res_sel = RES_NONE;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
			end
			ST_NB: begin
				cmd.rd_nb   = status.nb_ok;
				cmd.nb_step = !status.nb_ok && !status.k_last;
			end
			ST_CHK: begin
				cmd.visit   = status.cand;
				cmd.res_set = status.cand && status.hit;
				cmd.res_sel = RES_FOUND;
				cmd.enq     = status.cand && !status.hit;
				cmd.nb_step = !(status.cand && status.hit) && !status.k_last;
			end
			ST_FINISH: begin
				cmd.out_load = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ design/grid_bfs_shortest_path.sv @@
// A map write is taken in the idle state; a query with start equal to end or off the map ends after the check.
// Other queries first clear all 2^(2*clog2(GRID_SIDE)) visited-map entries (1024 at 32), then
// dequeue cells one by one and examine up to four neighbours of each.
// One transaction at a time: a new request is accepted only in the idle state.
// A finished result waits in the output register while the next transaction is accepted.
// Reset clears control and sets grid_side to 32; the wall map keeps its contents.
`timescale 1ns / 1ps

module grid_bfs_shortest_path import gbsp_pkg::*; #(
	parameter int GRID_SIDE = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [CFG_W-1:0]   cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [COORD_W-1:0] row,
	input  logic [COORD_W-1:0] col,
	input  logic               wall,
	input  logic [COORD_W-1:0] dest_row,
	input  logic [COORD_W-1:0] dest_col,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [DIST_W-1:0]  distance,
	output logic               reachable
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequencer
	gbsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Memories and arithmetic
	gbsp_dp #(
		.GRID_SIDE (GRID_SIDE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.row         (row),
		.col         (col),
		.wall        (wall),
		.dest_row    (dest_row),
		.dest_col    (dest_col),
		.distance    (distance),
		.reachable   (reachable)
	);

endmodule

@@ verif/grid_bfs_shortest_path_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the grid shortest-path block: map preload, directed and random queries.
module grid_bfs_shortest_path_tb import gbsp_pkg::*;;

	localparam int MAP_SIDE    = 32;
	localparam int MAP_CELLS   = MAP_SIDE * MAP_SIDE;
	localparam int FILL_SIDE   = 6;
	localparam int SETTLE_WAIT = 16;

	typedef struct packed {
		logic [DIST_W-1:0] steps;
		logic              reach;
	} path_result_t;

	// Mirror of the obstacle map, the side in use and the distances still owed
	class path_board;
		bit               wall_cells [MAP_CELLS];
		logic [CFG_W-1:0] side_cfg;
		path_result_t     expected_paths [$];
		int               errors;

		function new();
			side_cfg = GRID_SIDE_RESET;
			errors   = 0;
		endfunction

		function void set_side(logic [CFG_W-1:0] v);
			side_cfg = v;
		endfunction

		function int pending();
			return expected_paths.size();
		endfunction

		// Breadth-first search over free cells, neighbours in up, left, right, down order
		function path_result_t shortest_path(int sr, int sc, int tr, int tc);
			path_result_t res;
			int           lim;
			bit           seen [MAP_CELLS];
			int           cell_q [$];
			int           dist_q [$];
			int           pos, d, r, c, nr, nc, npos;
			dir_t         dir;
			res.steps = '0;
			res.reach = 1'b0;
			lim = (side_cfg > MAP_SIDE) ? MAP_SIDE : int'(side_cfg);
			seen = '{default: 1'b0};
			// Same cell wins over everything, even off the map
			if (sr == tr && sc == tc) begin
				res.reach = 1'b1;
				return res;
			end
			if (sr >= lim || sc >= lim || tr >= lim || tc >= lim)
				return res;
			seen[sr * MAP_SIDE + sc] = 1'b1;
			cell_q = {cell_q, sr * MAP_SIDE + sc};
			dist_q = {dist_q, 0};
			while (cell_q.size() != 0) begin
				pos = cell_q.pop_front();
				d   = dist_q.pop_front();
				r   = pos / MAP_SIDE;
				c   = pos % MAP_SIDE;
				for (int k = 0; k < 4; k++) begin
					dir = dir_t'(k);
					nr  = r;
					nc  = c;
					case (dir)
						DIR_UP:    nr = r - 1;
						DIR_LEFT:  nc = c - 1;
						DIR_RIGHT: nc = c + 1;
						DIR_DOWN:  nr = r + 1;
						default:   ;
					endcase
					if (nr < 0 || nc < 0 || nr >= lim || nc >= lim)
						continue;
					npos = nr * MAP_SIDE + nc;
					if (wall_cells[npos] || seen[npos])
						continue;
					seen[npos] = 1'b1;
					if (nr == tr && nc == tc) begin
						res.steps = (d + 1 > int'(DIST_MAX)) ? DIST_MAX : DIST_W'(d + 1);
						res.reach = 1'b1;
						return res;
					end
					cell_q = {cell_q, npos};
					dist_q = {dist_q, d + 1};
				end
			end
			return res;
		endfunction

		// Apply an accepted transaction: store a wall bit or queue the expected distance
		function void note_request(logic req, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
				logic w, logic [COORD_W-1:0] tr, logic [COORD_W-1:0] tc);
			if (req == REQ_WRITE)
				wall_cells[int'(r) * MAP_SIDE + int'(c)] = w;
			else
				expected_paths = {expected_paths,
					shortest_path(int'(r), int'(c), int'(tr), int'(tc))};
		endfunction

		function void check_result(logic [DIST_W-1:0] got_steps, logic reach);
			path_result_t exp_res;
			if (expected_paths.size() == 0) begin
				$display("%0t: unexpected result: distance %0d reachable %0b", $time,
					got_steps, reach);
				errors++;
				return;
			end
			exp_res = expected_paths.pop_front();
			if (got_steps !== exp_res.steps) begin
				$display("%0t: distance mismatch: expected %0d, actual %0d",
					$time, exp_res.steps, got_steps);
				errors++;
			end
			if (reach !== exp_res.reach) begin
				$display("%0t: reachable mismatch: expected %0b, actual %0b",
					$time, exp_res.reach, reach);
				errors++;
			end
		endfunction
	endclass

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               cfg_wr_en   = 1'b0;
	logic [CFG_W-1:0]   cfg_wr_data = '0;
	logic               in_valid    = 1'b0;
	logic               req_type    = REQ_WRITE;
	logic [COORD_W-1:0] row         = '0;
	logic [COORD_W-1:0] col         = '0;
	logic               wall        = 1'b0;
	logic [COORD_W-1:0] dest_row    = '0;
	logic [COORD_W-1:0] dest_col    = '0;
	logic               out_stall   = 1'b0;
	logic               in_stall;
	logic               out_valid;
	logic [DIST_W-1:0]  distance;
	logic               reachable;

	path_board sb;
	int        tx_calm    = 0;
	int        stall_left = 0;
	int        rx_calm    = 0;

	grid_bfs_shortest_path #(.GRID_SIDE(MAP_SIDE)) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.row         (row),
		.col         (col),
		.wall        (wall),
		.dest_row    (dest_row),
		.dest_col    (dest_col),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.distance    (distance),
		.reachable   (reachable)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Stall the result side in short and long bursts, with calm spells in between
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (rx_calm != 0) begin
			rx_calm--;
			out_stall <= 1'b0;
		end else begin
			case ($urandom_range(0, 15))
				0:       rx_calm = $urandom_range(100, 400);
				1, 2, 3: stall_left = ($urandom_range(0, 5) == 0) ?
					$urandom_range(20, 80) : $urandom_range(1, 3);
				default: ;
			endcase
			out_stall <= (stall_left != 0);
		end
	end

	// Check every result transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(distance, reachable);
	end

	// Hold the sender off for a random gap: mostly none or short, now and then long
	task automatic pause_sender();
		int n;
		int roll;
		n = 0;
		if (tx_calm > 0) begin
			tx_calm--;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 3)
				tx_calm = $urandom_range(20, 60);
			else if (roll < 50)
				n = 0;
			else if (roll < 90)
				n = $urandom_range(1, 3);
			else
				n = $urandom_range(10, 60);
		end
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_item(logic req, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
			logic w, logic [COORD_W-1:0] tr, logic [COORD_W-1:0] tc);
		in_valid <= 1'b1;
		req_type <= req;
		row      <= r;
		col      <= c;
		wall     <= w;
		dest_row <= tr;
		dest_col <= tc;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_request(req, r, c, w, tr, tc);
		pause_sender();
	endtask

	task automatic query(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
			logic [COORD_W-1:0] tr, logic [COORD_W-1:0] tc);
		send_item(REQ_QUERY, r, c, 1'($urandom_range(0, 1)), tr, tc);
	endtask

	task automatic write_cell(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c, logic w);
		send_item(REQ_WRITE, r, c, w, COORD_W'($urandom_range(0, 31)),
			COORD_W'($urandom_range(0, 31)));
	endtask

	// Drop valid and wait until every owed result has come and the block has settled
	task automatic wait_for_quiet();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic set_grid_side(logic [CFG_W-1:0] v);
		wait_for_quiet();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_side(v);
	endtask

	// Random mix of map edits and queries at one side setting
	task automatic random_phase(logic [CFG_W-1:0] side_val, int count);
		int                 eff;
		int                 hi;
		int                 roll;
		int                 wall_pct;
		logic [COORD_W-1:0] r, c, tr, tc;
		set_grid_side(side_val);
		eff      = (side_val > MAP_SIDE) ? MAP_SIDE : int'(side_val);
		hi       = (eff < 2) ? 1 : eff - 1;
		wall_pct = $urandom_range(1, 5) * 10;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			r    = COORD_W'($urandom_range(0, hi));
			c    = COORD_W'($urandom_range(0, hi));
			tr   = COORD_W'($urandom_range(0, hi));
			tc   = COORD_W'($urandom_range(0, hi));
			if (roll < 35)
				write_cell(r, c, $urandom_range(0, 99) < wall_pct);
			else if (roll < 40)
				write_cell(COORD_W'($urandom_range(0, 31)), COORD_W'($urandom_range(0, 31)),
					1'($urandom_range(0, 1)));
			else if (roll < 82)
				query(r, c, tr, tc);
			else if (roll < 90) begin
				r = COORD_W'($urandom_range(0, 31));
				c = COORD_W'($urandom_range(0, 31));
				query(r, c, r, c);
			end else
				query(COORD_W'($urandom_range(0, 31)), COORD_W'($urandom_range(0, 31)),
					COORD_W'($urandom_range(0, 31)), COORD_W'($urandom_range(0, 31)));
			if ($urandom_range(0, 29) == 0)
				wait_for_quiet();
		end
	endtask

	initial begin
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the corner region; every search below stays on written cells
		for (int r = 0; r < FILL_SIDE; r++)
			for (int c = 0; c < FILL_SIDE; c++)
				write_cell(COORD_W'(r), COORD_W'(c), $urandom_range(0, 3) == 0);

		// Full-size map: same cell, boxed-in start, walled start
		query(5'd31, 5'd31, 5'd31, 5'd31);
		write_cell(5'd0, 5'd1, 1'b1);
		write_cell(5'd1, 5'd0, 1'b1);
		query(5'd0, 5'd0, 5'd5, 5'd5);
		write_cell(5'd31, 5'd0, 1'b1);
		write_cell(5'd30, 5'd0, 1'b1);
		write_cell(5'd31, 5'd1, 1'b0);
		query(5'd31, 5'd0, 5'd31, 5'd1);

		// Oversized side saturates to the full map: the far corner has no way out
		set_grid_side(6'd63);
		write_cell(5'd30, 5'd31, 1'b1);
		write_cell(5'd31, 5'd30, 1'b1);
		query(5'd31, 5'd31, 5'd0, 5'd0);

		// Small side: cells off the map, same cell off the map, wall target
		set_grid_side(6'd4);
		query(5'd0, 5'd0, 5'd4, 5'd0);
		query(5'd5, 5'd5, 5'd5, 5'd5);
		write_cell(5'd0, 5'd1, 1'b0);
		query(5'd0, 5'd0, 5'd3, 5'd3);
		write_cell(5'd2, 5'd2, 1'b1);
		query(5'd0, 5'd0, 5'd2, 5'd2);

		// Degenerate sides of zero and one
		set_grid_side(6'd0);
		query(5'd0, 5'd0, 5'd0, 5'd1);
		query(5'd0, 5'd0, 5'd0, 5'd0);
		set_grid_side(6'd1);
		query(5'd0, 5'd0, 5'd1, 5'd0);

		// Smallest useful side: open square, then blocked
		set_grid_side(6'd2);
		write_cell(5'd1, 5'd0, 1'b0);
		write_cell(5'd1, 5'd1, 1'b0);
		query(5'd0, 5'd0, 5'd1, 5'd1);
		write_cell(5'd0, 5'd1, 1'b1);
		write_cell(5'd1, 5'd0, 1'b1);
		query(5'd0, 5'd0, 5'd1, 5'd1);

		// Random phases inside the filled region
		random_phase(6'd3, 14);
		random_phase(6'd5, 16);
		random_phase(6'd2, 12);
		random_phase(6'd6, 18);
		random_phase(6'd4, 10);
		random_phase(6'd6, 8);

		wait_for_quiet();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog
	initial begin
		#100_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

@@ grid_bfs_shortest_path.f @@
design/gbsp_pkg.sv
design/gbsp_dp.sv
design/gbsp_ctrl.sv
design/grid_bfs_shortest_path.sv
verif/grid_bfs_shortest_path_tb.sv
